// ----- rtl/core/sfm_pkg.sv -----
// Shared constants and types for the segment frame matrix pipeline.
`default_nettype none
package sfm_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int RAD_WIDTH    = COORD_WIDTH - 1;
   localparam int UNIT_BITS    = 30;
   localparam int NORM_WIDTH   = 30;
   localparam int SQ_WIDTH     = 62;
   localparam int ROOT_WIDTH   = 31;
   localparam int LANES        = 5;
   localparam int LANE_SA      = 3;
   localparam int LANE_SB      = 4;
   localparam int THRESH_RECIP = 100000000;

   localparam int FRONT_STAGES = 9;
   localparam int ROOT_STAGES  = 31;
   localparam int DIV_STEPS    = 31;
   localparam int DIV_STAGES   = DIV_STEPS + 2;
   localparam int BACK_STAGES  = 4;
   localparam int LATENCY      = FRONT_STAGES + ROOT_STAGES + DIV_STAGES + BACK_STAGES;

   localparam logic [RAD_WIDTH-1:0] MIN_RADIUS_RESET =
      RAD_WIDTH'(((1 << FRAC_BITS) + 500) / 1000);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0]        start;
      coord_type [2:0]        axis;
      logic [RAD_WIDTH-1:0]   radius;
      logic [2:0]             neg;
      logic [1:0]             sneg;
      logic                   nz;
      logic                   vert;
   } sfm_carry_type;

   typedef struct packed {
      sfm_carry_type                    carry;
      logic [SQ_WIDTH-1:0]              n_l;
      logic [SQ_WIDTH-1:0]              n_s;
      logic [4:0]                       k_l;
      logic [4:0]                       k_s;
      logic [LANES-1:0][NORM_WIDTH-1:0] mag;
   } sfm_front_type;

   typedef struct packed {
      sfm_carry_type                    carry;
      logic [4:0]                       k_l;
      logic [4:0]                       k_s;
      logic [LANES-1:0][NORM_WIDTH-1:0] mag;
      logic [ROOT_WIDTH-1:0]            q_l;
      logic [ROOT_WIDTH-1:0]            q_s;
   } sfm_root_type;

   typedef struct packed {
      sfm_carry_type   carry;
      coord_type [2:0] f;
      coord_type [2:0] s;
   } sfm_unit_type;

   typedef struct packed {
      coord_type [2:0] side;
      coord_type [2:0] up;
      coord_type [2:0] axis;
      coord_type [2:0] origin;
   } sfm_result_type;

endpackage
`default_nettype wire

// ----- rtl/core/segment_frame_matrix.sv -----
// Top level of the segment frame matrix pipeline.
`default_nettype none
// Segment frame matrix: one segment is taken in every clock cycle (start high, busy is
// always low) and its 3x4 frame columns appear on the rsp_ ports, marked by a one-cycle
// rsp_valid strobe, in input order. The pipeline is a 31-stage square root and a 33-stage
// restoring divider (31 quotient bit stages plus an entry and an output register), each
// chain resolving one bit per stage, plus nine front stages (normalize, squares, side
// select) and four back stages (cross product, radius scale, saturate). The receiver has
// no way to stall; results must be taken when strobed. min_radius is sampled as a
// segment enters, so write csr_ only while the pipeline is empty.
module segment_frame_matrix
   import sfm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [31:0]     req_start_x,
   input  logic signed [31:0]     req_start_y,
   input  logic signed [31:0]     req_start_z,
   input  logic signed [31:0]     req_end_x,
   input  logic signed [31:0]     req_end_y,
   input  logic signed [31:0]     req_end_z,
   input  logic [RAD_WIDTH-1:0]   req_seg_radius,
   input  logic                   csr_we,
   input  logic [RAD_WIDTH-1:0]   csr_wdata,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_side_scaled_x,
   output logic signed [31:0]     rsp_side_scaled_y,
   output logic signed [31:0]     rsp_side_scaled_z,
   output logic signed [31:0]     rsp_up_scaled_x,
   output logic signed [31:0]     rsp_up_scaled_y,
   output logic signed [31:0]     rsp_up_scaled_z,
   output logic signed [31:0]     rsp_axis_x,
   output logic signed [31:0]     rsp_axis_y,
   output logic signed [31:0]     rsp_axis_z,
   output logic signed [31:0]     rsp_origin_x,
   output logic signed [31:0]     rsp_origin_y,
   output logic signed [31:0]     rsp_origin_z
);

   logic [RAD_WIDTH-1:0] min_radius_ff, min_radius_in;
   coord_type [2:0]      start_pt, end_pt;
   logic                 front_valid, root_valid, div_valid, back_valid;
   sfm_front_type        front_data;
   sfm_root_type         root_data;
   sfm_unit_type         div_data;
   sfm_result_type       back_data;

   assign busy = 1'b0;
   assign min_radius_in = csr_we ? csr_wdata : min_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) min_radius_ff <= MIN_RADIUS_RESET;
      else min_radius_ff <= min_radius_in;
   end

   assign start_pt = {req_start_z, req_start_y, req_start_x};
   assign end_pt = {req_end_z, req_end_y, req_end_x};

   sfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .start_pt   (start_pt),
      .end_pt     (end_pt),
      .radius     (req_seg_radius),
      .min_radius (min_radius_ff),
      .out_valid  (front_valid),
      .out_data   (front_data)
   );

   sfm_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   sfm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_data   (root_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   sfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   assign rsp_valid = back_valid;
   assign rsp_side_scaled_x = back_data.side[0];
   assign rsp_side_scaled_y = back_data.side[1];
   assign rsp_side_scaled_z = back_data.side[2];
   assign rsp_up_scaled_x = back_data.up[0];
   assign rsp_up_scaled_y = back_data.up[1];
   assign rsp_up_scaled_z = back_data.up[2];
   assign rsp_axis_x = back_data.axis[0];
   assign rsp_axis_y = back_data.axis[1];
   assign rsp_axis_z = back_data.axis[2];
   assign rsp_origin_x = back_data.origin[0];
   assign rsp_origin_y = back_data.origin[1];
   assign rsp_origin_z = back_data.origin[2];

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transfer lost in pipeline");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_origin_x == $past(req_start_x, LATENCY)))
      else $error("origin out of step with its segment");

   // zero-length segment: no frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_axis_x == 0 && rsp_axis_y == 0 && rsp_axis_z == 0) |->
      (rsp_side_scaled_x == 0 && rsp_side_scaled_y == 0 && rsp_side_scaled_z == 0 &&
       rsp_up_scaled_x == 0 && rsp_up_scaled_y == 0 && rsp_up_scaled_z == 0))
      else $error("frame on zero-length segment");

endmodule
`default_nettype wire

// ----- rtl/core/sfm_front.sv -----
// Front end: direction, block normalization, squared lengths, side select, root pre-shift.
`default_nettype none
module sfm_front
   import sfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  coord_type [2:0]      start_pt,
   input  coord_type [2:0]      end_pt,
   input  logic [RAD_WIDTH-1:0] radius,
   input  logic [RAD_WIDTH-1:0] min_radius,
   output logic                 out_valid,
   output sfm_front_type        out_data
);

   localparam logic [5:0] NORM_TOP = 6'(NORM_WIDTH - 1);
   localparam logic [5:0] ROOT_TOP = 6'(SQ_WIDTH - 2);

   function automatic logic [5:0] lead_pos33(logic [32:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 33; i++) if (v[i]) p = 6'(i);
      return p;
   endfunction

   // two-bit shifts that bring the value up to the top quarter
   function automatic logic [4:0] quad_shift(logic [SQ_WIDTH-1:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < SQ_WIDTH; i++) if (v[i]) p = 6'(i);
      if (p >= ROOT_TOP) return '0;
      return 5'((7'(ROOT_TOP) + 7'd1 - {1'b0, p}) >> 1);
   endfunction

   logic [FRONT_STAGES-1:0] vld_ff, vld_in;

   sfm_carry_type c1_ff, c1_in, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff, c7_in, c8_ff;
   logic [2:0][32:0]           a1_ff, a1_in, a2_ff;
   logic [32:0]                or1_ff, or1_in;
   logic [5:0]                 pos2_ff;
   logic [2:0][NORM_WIDTH-1:0] e3_ff, e3_in, e4_ff, e5_ff, e6_ff;
   logic [2:0][59:0]           sq4_ff, sq4_in;
   logic [SQ_WIDTH-1:0]        l2_5_ff, l2_6_ff, l2_7_ff, l2_8_ff;
   logic [SQ_WIDTH-2:0]        h2_5_ff, h2_6_ff, g2_5_ff, g2_6_ff, ns7_ff, ns7_in, ns8_ff;
   logic                       big6_ff;
   logic [62:0]                prod6_ff;
   logic [LANES-1:0][NORM_WIDTH-1:0] mag7_ff, mag7_in, mag8_ff;
   logic [4:0]                 kl8_ff, ks8_ff;
   sfm_front_type              out_ff, out_in;

   logic [2:0][32:0] d1;

   assign vld_in = {vld_ff[FRONT_STAGES-2:0], in_valid};

   always_comb begin
      c1_in = '0;
      for (int i = 0; i < 3; i++) begin
         d1[i] = {end_pt[i][COORD_WIDTH-1], end_pt[i]} - {start_pt[i][COORD_WIDTH-1], start_pt[i]};
         a1_in[i] = d1[i][32] ? 33'(-d1[i]) : d1[i];
         c1_in.start[i] = start_pt[i];
         c1_in.neg[i] = d1[i][32];
         if (d1[i][32] != d1[i][31])
            c1_in.axis[i] = d1[i][32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
         else
            c1_in.axis[i] = d1[i][31:0];
      end
      or1_in = a1_in[0] | a1_in[1] | a1_in[2];
      c1_in.nz = |or1_in;
      c1_in.radius = (radius < min_radius) ? min_radius : radius;
   end

   // shift all magnitudes together so the largest leads at the top bit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff >= NORM_TOP) e3_in[i] = NORM_WIDTH'(a2_ff[i] >> (pos2_ff - NORM_TOP));
         else e3_in[i] = NORM_WIDTH'(a2_ff[i] << (NORM_TOP - pos2_ff));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) sq4_in[i] = {30'b0, e3_ff[i]} * {30'b0, e3_ff[i]};
   end

   // side from f x (0,1,0) unless the segment is near vertical
   always_comb begin
      logic normal;
      normal = big6_ff || (prod6_ff >= {1'b0, l2_6_ff});
      ns7_in = normal ? h2_6_ff : g2_6_ff;
      mag7_in[0] = e6_ff[0];
      mag7_in[1] = e6_ff[1];
      mag7_in[2] = e6_ff[2];
      mag7_in[LANE_SA] = e6_ff[2];
      mag7_in[LANE_SB] = normal ? e6_ff[0] : e6_ff[1];
      c7_in = c6_ff;
      c7_in.vert = !normal;
      c7_in.sneg[0] = normal ? !c6_ff.neg[2] : c6_ff.neg[2];
      c7_in.sneg[1] = normal ? c6_ff.neg[0] : !c6_ff.neg[1];
   end

   always_comb begin
      out_in.carry = c8_ff;
      out_in.k_l = kl8_ff;
      out_in.k_s = ks8_ff;
      out_in.mag = mag8_ff;
      out_in.n_l = l2_8_ff << {kl8_ff, 1'b0};
      out_in.n_s = {1'b0, ns8_ff} << {ks8_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      c1_ff <= c1_in;
      a1_ff <= a1_in;
      or1_ff <= or1_in;
      c2_ff <= c1_ff;
      a2_ff <= a1_ff;
      pos2_ff <= lead_pos33(or1_ff);
      c3_ff <= c2_ff;
      e3_ff <= e3_in;
      c4_ff <= c3_ff;
      e4_ff <= e3_ff;
      sq4_ff <= sq4_in;
      c5_ff <= c4_ff;
      e5_ff <= e4_ff;
      l2_5_ff <= SQ_WIDTH'(sq4_ff[0]) + SQ_WIDTH'(sq4_ff[1]) + SQ_WIDTH'(sq4_ff[2]);
      h2_5_ff <= (SQ_WIDTH-1)'(sq4_ff[0]) + (SQ_WIDTH-1)'(sq4_ff[2]);
      g2_5_ff <= (SQ_WIDTH-1)'(sq4_ff[1]) + (SQ_WIDTH-1)'(sq4_ff[2]);
      c6_ff <= c5_ff;
      e6_ff <= e5_ff;
      l2_6_ff <= l2_5_ff;
      h2_6_ff <= h2_5_ff;
      g2_6_ff <= g2_5_ff;
      big6_ff <= |h2_5_ff[SQ_WIDTH-2:36];
      prod6_ff <= {27'b0, h2_5_ff[35:0]} * 63'(THRESH_RECIP);
      c7_ff <= c7_in;
      l2_7_ff <= l2_6_ff;
      ns7_ff <= ns7_in;
      mag7_ff <= mag7_in;
      c8_ff <= c7_ff;
      l2_8_ff <= l2_7_ff;
      ns8_ff <= ns7_ff;
      mag8_ff <= mag7_ff;
      kl8_ff <= quad_shift(l2_7_ff);
      ks8_ff <= quad_shift({1'b0, ns7_ff});
      out_ff <= out_in;
   end

   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_data = out_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sfm_root.sv -----
// Pipelined integer square root, two lanes, one result bit per stage.
`default_nettype none
module sfm_root
   import sfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  sfm_front_type in_data,
   output logic          out_valid,
   output sfm_root_type  out_data
);

   typedef struct packed {
      sfm_carry_type                    carry;
      logic [4:0]                       k_l;
      logic [4:0]                       k_s;
      logic [LANES-1:0][NORM_WIDTH-1:0] mag;
      logic [62:0]                      v_l;
      logic [62:0]                      r_l;
      logic [62:0]                      v_s;
      logic [62:0]                      r_s;
   } root_stage_type;

   logic [ROOT_STAGES-1:0] vld_ff;
   root_stage_type         st_ff [ROOT_STAGES];
   root_stage_type         st_in [ROOT_STAGES];
   root_stage_type         prev  [ROOT_STAGES];

   always_comb begin
      prev[0].carry = in_data.carry;
      prev[0].k_l = in_data.k_l;
      prev[0].k_s = in_data.k_s;
      prev[0].mag = in_data.mag;
      prev[0].v_l = {1'b0, in_data.n_l};
      prev[0].v_s = {1'b0, in_data.n_s};
      prev[0].r_l = '0;
      prev[0].r_s = '0;
      for (int j = 1; j < ROOT_STAGES; j++) prev[j] = st_ff[j-1];
   end

   for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_step
      localparam logic [62:0] BIT = 63'(1) << (2 * (ROOT_STAGES - 1 - j));
      always_comb begin
         logic [62:0] sum_l, sum_s;
         sum_l = prev[j].r_l + BIT;
         sum_s = prev[j].r_s + BIT;
         st_in[j] = prev[j];
         if (prev[j].v_l >= sum_l) begin
            st_in[j].v_l = prev[j].v_l - sum_l;
            st_in[j].r_l = (prev[j].r_l >> 1) + BIT;
         end else begin
            st_in[j].r_l = prev[j].r_l >> 1;
         end
         if (prev[j].v_s >= sum_s) begin
            st_in[j].v_s = prev[j].v_s - sum_s;
            st_in[j].r_s = (prev[j].r_s >> 1) + BIT;
         end else begin
            st_in[j].r_s = prev[j].r_s >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[ROOT_STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ROOT_STAGES; j++) st_ff[j] <= st_in[j];
   end

   assign out_valid = vld_ff[ROOT_STAGES-1];
   assign out_data.carry = st_ff[ROOT_STAGES-1].carry;
   assign out_data.k_l = st_ff[ROOT_STAGES-1].k_l;
   assign out_data.k_s = st_ff[ROOT_STAGES-1].k_s;
   assign out_data.mag = st_ff[ROOT_STAGES-1].mag;
   assign out_data.q_l = st_ff[ROOT_STAGES-1].r_l[ROOT_WIDTH-1:0];
   assign out_data.q_s = st_ff[ROOT_STAGES-1].r_s[ROOT_WIDTH-1:0];

   // the long root lane (r_l) never exceeds its result width
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (st_ff[ROOT_STAGES-1].r_l[62:ROOT_WIDTH] == '0))
      else $error("root lane overflow");

endmodule
`default_nettype wire

// ----- rtl/core/sfm_div.sv -----
// Pipelined restoring divider, five lanes: unit components in Q1.30.
`default_nettype none
module sfm_div
   import sfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  sfm_root_type in_data,
   output logic         out_valid,
   output sfm_unit_type out_data
);

   localparam int STEPS = DIV_STEPS + 1;

   typedef struct packed {
      sfm_carry_type                    carry;
      logic [ROOT_WIDTH-1:0]            q_l;
      logic [ROOT_WIDTH-1:0]            q_s;
      logic [LANES-1:0][ROOT_WIDTH-1:0] rem;
      logic [LANES-1:0][ROOT_WIDTH-1:0] low;
      logic [LANES-1:0][ROOT_WIDTH-1:0] quo;
   } div_stage_type;

   logic [DIV_STAGES-1:0] vld_ff;
   div_stage_type         st_ff [STEPS];
   div_stage_type         st_in [STEPS];
   sfm_unit_type          out_ff, out_in;

   // numerator = (mag << k) << 30 plus half the divisor for rounding
   always_comb begin
      logic [SQ_WIDTH-1:0]   num;
      logic [ROOT_WIDTH-1:0] q;
      logic [4:0]            k;
      st_in[0].carry = in_data.carry;
      st_in[0].q_l = in_data.q_l;
      st_in[0].q_s = in_data.q_s;
      st_in[0].quo = '0;
      for (int i = 0; i < LANES; i++) begin
         q = (i < LANE_SA) ? in_data.q_l : in_data.q_s;
         k = (i < LANE_SA) ? in_data.k_l : in_data.k_s;
         num = ((SQ_WIDTH'(in_data.mag[i]) << k) << UNIT_BITS) + SQ_WIDTH'(q >> 1);
         st_in[0].rem[i] = num[SQ_WIDTH-1:ROOT_WIDTH];
         st_in[0].low[i] = num[ROOT_WIDTH-1:0];
      end
   end

   for (genvar j = 1; j < STEPS; j++) begin : g_step
      always_comb begin
         logic [ROOT_WIDTH:0]   rem2;
         logic [ROOT_WIDTH-1:0] q;
         st_in[j] = st_ff[j-1];
         for (int i = 0; i < LANES; i++) begin
            q = (i < LANE_SA) ? st_ff[j-1].q_l : st_ff[j-1].q_s;
            rem2 = {st_ff[j-1].rem[i], st_ff[j-1].low[i][ROOT_WIDTH-1]};
            st_in[j].low[i] = st_ff[j-1].low[i] << 1;
            if (rem2 >= {1'b0, q}) begin
               st_in[j].rem[i] = ROOT_WIDTH'(rem2 - {1'b0, q});
               st_in[j].quo[i] = {st_ff[j-1].quo[i][ROOT_WIDTH-2:0], 1'b1};
            end else begin
               st_in[j].rem[i] = rem2[ROOT_WIDTH-1:0];
               st_in[j].quo[i] = {st_ff[j-1].quo[i][ROOT_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   // apply signs and place the side lanes by branch
   always_comb begin
      coord_type qa, qb, mag;
      out_in.carry = st_ff[STEPS-1].carry;
      for (int i = 0; i < 3; i++) begin
         mag = {1'b0, st_ff[STEPS-1].quo[i]};
         out_in.f[i] = st_ff[STEPS-1].carry.neg[i] ? -mag : mag;
      end
      mag = {1'b0, st_ff[STEPS-1].quo[LANE_SA]};
      qa = st_ff[STEPS-1].carry.sneg[0] ? -mag : mag;
      mag = {1'b0, st_ff[STEPS-1].quo[LANE_SB]};
      qb = st_ff[STEPS-1].carry.sneg[1] ? -mag : mag;
      out_in.s[2] = qb;
      if (st_ff[STEPS-1].carry.vert) begin
         out_in.s[0] = '0;
         out_in.s[1] = qa;
      end else begin
         out_in.s[0] = qa;
         out_in.s[1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STEPS; j++) st_ff[j] <= st_in[j];
      out_ff <= out_in;
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_data = out_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sfm_back.sv -----
// Back end: up = side x forward, radius scaling, saturation and output register.
`default_nettype none
module sfm_back
   import sfm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  sfm_unit_type   in_data,
   output logic           out_valid,
   output sfm_result_type out_data
);

   localparam logic [63:0] HALF = 64'(1) << (UNIT_BITS - 1);

   logic [BACK_STAGES-1:0] vld_ff;

   sfm_carry_type c1_ff, c2_ff, c3_ff;
   coord_type [2:0] s1_ff, s2_ff;
   coord_type [2:0] u2_ff, u2_in;
   logic signed [5:0][63:0] p1_ff, p1_in;
   logic [5:0][61:0] m3_ff, m3_in;
   logic [5:0]       n3_ff, n3_in;
   sfm_result_type   out_ff, out_in;

   always_comb begin
      p1_in[0] = $signed(in_data.s[1]) * $signed(in_data.f[2]);
      p1_in[1] = $signed(in_data.s[2]) * $signed(in_data.f[1]);
      p1_in[2] = $signed(in_data.s[2]) * $signed(in_data.f[0]);
      p1_in[3] = $signed(in_data.s[0]) * $signed(in_data.f[2]);
      p1_in[4] = $signed(in_data.s[0]) * $signed(in_data.f[1]);
      p1_in[5] = $signed(in_data.s[1]) * $signed(in_data.f[0]);
   end

   // round Q2.60 to Q1.30, half away from zero
   always_comb begin
      logic [63:0] diff, mag, r;
      for (int i = 0; i < 3; i++) begin
         diff = p1_ff[2*i] - p1_ff[2*i+1];
         mag = diff[63] ? -diff : diff;
         r = (mag + HALF) >> UNIT_BITS;
         u2_in[i] = diff[63] ? -COORD_WIDTH'(r) : COORD_WIDTH'(r);
      end
   end

   always_comb begin
      coord_type x;
      logic [COORD_WIDTH-1:0] mag;
      for (int i = 0; i < 6; i++) begin
         x = (i < 3) ? s2_ff[i] : u2_ff[i-3];
         mag = x[COORD_WIDTH-1] ? -x : x;
         n3_in[i] = x[COORD_WIDTH-1];
         m3_in[i] = {31'b0, c2_ff.radius} * {31'b0, mag[RAD_WIDTH-1:0]};
      end
   end

   always_comb begin
      logic [62:0] v;
      coord_type   y;
      for (int i = 0; i < 6; i++) begin
         v = ({1'b0, m3_ff[i]} + 63'(HALF)) >> UNIT_BITS;
         if (n3_ff[i]) y = (v[32:0] >= 33'h1_0000_0000 >> 1) ? {1'b1, 31'b0} : -v[31:0];
         else y = (v[32:0] >= 33'h1_0000_0000 >> 1) ? {1'b0, {31{1'b1}}} : v[31:0];
         if (!c3_ff.nz) y = '0;
         if (i < 3) out_in.side[i] = y;
         else out_in.up[i-3] = y;
      end
      out_in.axis = c3_ff.axis;
      out_in.origin = c3_ff.start;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[BACK_STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      c1_ff <= in_data.carry;
      s1_ff <= in_data.s;
      p1_ff <= p1_in;
      c2_ff <= c1_ff;
      s2_ff <= s1_ff;
      u2_ff <= u2_in;
      c3_ff <= c2_ff;
      m3_ff <= m3_in;
      n3_ff <= n3_in;
      out_ff <= out_in;
   end

   assign out_valid = vld_ff[BACK_STAGES-1];
   assign out_data = out_ff;

endmodule
`default_nettype wire
